>>> src/lfsp_pkg.sv
`timescale 1ns / 1ps

package lfsp_pkg;

    localparam int THR_W      = 12;
    localparam int SPD_W      = 8;
    localparam int PROD_W     = THR_W + SPD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [1:0]           marker_t;

    localparam cfg_idx_t REG_TURN_THR     = 3'd0;
    localparam cfg_idx_t REG_STRAIGHT_THR = 3'd1;
    localparam cfg_idx_t REG_TURN_SPEED   = 3'd2;
    localparam cfg_idx_t REG_SLOW_SPEED   = 3'd3;
    localparam cfg_idx_t REG_FAST_SPEED   = 3'd4;
    localparam cfg_idx_t REG_BOOST_LEN    = 3'd5;
    localparam cfg_idx_t REG_ACCEL_STEP   = 3'd6;
    localparam cfg_idx_t REG_DECEL_STEP   = 3'd7;

    localparam logic [THR_W-1:0] RST_TURN_THR     = 12'd600;
    localparam logic [THR_W-1:0] RST_STRAIGHT_THR = 12'd200;
    localparam logic [SPD_W-1:0] RST_TURN_SPEED   = 8'd100;
    localparam logic [SPD_W-1:0] RST_SLOW_SPEED   = 8'd150;
    localparam logic [SPD_W-1:0] RST_FAST_SPEED   = 8'd220;
    localparam logic [SPD_W-1:0] RST_BOOST_LEN    = 8'd10;
    localparam logic [SPD_W-1:0] RST_ACCEL_STEP   = 8'd5;
    localparam logic [SPD_W-1:0] RST_DECEL_STEP   = 8'd10;

    localparam marker_t MK_NONE  = 2'd0;
    localparam marker_t MK_LEFT  = 2'd1;
    localparam marker_t MK_RIGHT = 2'd2;
    localparam marker_t MK_BOTH  = 2'd3;

    localparam logic [SPD_W:0] BOOST_BONUS = 9'd30;
    localparam logic [SPD_W:0] SPEED_MAX   = 9'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_CLASS,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } lfsp_state_t;

endpackage

>>> src/lfsp_bit_mul.sv
`timescale 1ns / 1ps

// Shift-and-add multiplier, one multiplier bit per cycle, most significant first.
module lfsp_bit_mul
    import lfsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [THR_W-1:0]  a_in,
    input  logic [SPD_W-1:0]  b_in,
    output logic              busy,
    output logic [PROD_W-1:0] product
);

    localparam int CNT_W = $clog2(SPD_W + 1);

    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [THR_W-1:0]  a_reg, a_next;
    logic [SPD_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        acc_next = acc_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        cnt_next = cnt_reg;
        if (start) begin
            acc_next = '0;
            a_next   = a_in;
            b_next   = b_in;
            cnt_next = CNT_W'(SPD_W);
        end else if (cnt_reg != '0) begin
            acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                     + (b_reg[SPD_W-1] ? PROD_W'(a_reg) : '0);
            b_next   = {b_reg[SPD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

endmodule

>>> src/lfsp_bit_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2**SPD_W, so the upper part already starts as a valid remainder.
module lfsp_bit_div
    import lfsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [THR_W-1:0]  divisor,
    output logic              busy,
    output logic [SPD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(SPD_W + 1);

    logic [THR_W-1:0] rem_reg, rem_next;
    logic [THR_W-1:0] dvs_reg, dvs_next;
    logic [SPD_W-1:0] low_reg, low_next;
    logic [SPD_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [THR_W:0]   trial;
    logic [THR_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, low_reg[SPD_W-1]};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        low_next = low_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = dividend[PROD_W-1:SPD_W];
            low_next = dividend[SPD_W-1:0];
            dvs_next = divisor;
            q_next   = '0;
            cnt_next = CNT_W'(SPD_W);
        end else if (cnt_reg != '0) begin
            rem_next = fits ? trial_sub[THR_W-1:0] : trial[THR_W-1:0];
            low_next = {low_reg[SPD_W-2:0], 1'b0};
            q_next   = {q_reg[SPD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

>>> src/line_follower_speed_profiler_top.sv
`timescale 1ns / 1ps

// Speed profiler for a line-following robot: each request carries a signed
// line error and two course-marker bits and yields one result with the motor
// speed, the precision-mode flag and the finish, mode and crossing events.
// The block handles one request at a time. A request whose error lies between
// the two thresholds (with the thresholds unequal) is accepted, then goes
// through marker handling, classification, a bit-serial multiplier and a
// bit-serial divider (working bit by bit through the 8-bit speed difference
// and quotient), and a final step that slews and clamps the speed. Any other
// request skips the multiplier and divider. The result waits in an output
// register, and the next request is accepted while it is still pending.
module line_follower_speed_profiler_top
    import lfsp_pkg::*;
#(
    parameter int ERROR_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // line_error, left_marker, right_marker; zero padded
    input  logic [((ERROR_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // motor_speed[7:0], precision_on, finish_event, mode_event, crossing_event
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MAG_W = (ERROR_BITS > THR_W) ? ERROR_BITS : THR_W;

    lfsp_state_t state_reg, state_next;

    logic [THR_W-1:0] turn_thr_reg, turn_thr_next;
    logic [THR_W-1:0] straight_thr_reg, straight_thr_next;
    logic [SPD_W-1:0] turn_speed_reg, turn_speed_next;
    logic [SPD_W-1:0] slow_speed_reg, slow_speed_next;
    logic [SPD_W-1:0] fast_speed_reg, fast_speed_next;
    logic [SPD_W-1:0] boost_len_reg, boost_len_next;
    logic [SPD_W-1:0] accel_step_reg, accel_step_next;
    logic [SPD_W-1:0] decel_step_reg, decel_step_next;

    logic [SPD_W:0]   speed_reg, speed_next;
    logic             in_curve_reg, in_curve_next;
    logic             leaving_reg, leaving_next;
    logic [SPD_W-1:0] boost_reg, boost_next;
    logic             precision_reg, precision_next;
    marker_t          mk_last_reg, mk_last_next;
    marker_t          mk_prev_reg, mk_prev_next;
    marker_t          mk_older_reg, mk_older_next;

    logic                  ev_fin_reg, ev_fin_next;
    logic                  ev_mode_reg, ev_mode_next;
    logic                  ev_cross_reg, ev_cross_next;
    logic [ERROR_BITS-1:0] err_reg, err_next;
    logic                  left_reg, left_next;
    logic                  right_reg, right_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic in_fire, mark_en, mul_start, div_start, done_en, out_free;

    logic              mul_busy, div_busy;
    logic [PROD_W-1:0] mul_product;
    logic [SPD_W-1:0]  div_quotient;

    // Marker decode.
    marker_t mk_code;
    logic    mk_change, mk_fin, mk_mode, mk_cross;
    logic    [SPD_W-1:0] mark_ceil;

    // Error classification and interpolation.
    logic [ERROR_BITS-1:0] mag_e;
    logic [MAG_W-1:0]      mag;
    logic                  is_curve, is_straight, is_between;
    logic [THR_W-1:0]      span, mag_off;
    logic                  span_zero;
    logic [SPD_W-1:0]      ceil_speed, spd_diff_abs, interp;
    logic                  spd_diff_neg;

    // Final speed step.
    logic [SPD_W-1:0] base_target, target, step, boost_new, boost_final;
    logic             in_curve_new, leaving_new, boost_on, up;
    logic [SPD_W:0]   boosted, tgt9, adiff, speed_new;
    logic [SPD_W-1:0] res;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------- state machine ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MARK;
            ST_MARK:  state_next = ST_CLASS;
            ST_CLASS: state_next = (is_between && !span_zero) ? ST_MUL : ST_DONE;
            ST_MUL:   if (!mul_busy) state_next = ST_DIV;
            ST_DIV:   if (!div_busy) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        mark_en   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        done_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_MARK:  mark_en   = 1'b1;
            ST_CLASS: mul_start = is_between && !span_zero;
            ST_MUL:   div_start = !mul_busy;
            ST_DIV:   ;
            ST_DONE:  done_en   = out_free;
            default:  ;
        endcase
    end

    // ---------------- serial interpolation units ----------------
    lfsp_bit_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mag_off),
        .b_in    (spd_diff_abs),
        .busy    (mul_busy),
        .product (mul_product)
    );

    lfsp_bit_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (span),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // ---------------- marker logic ----------------
    assign mk_code   = {right_reg, left_reg};
    assign mk_change = (mk_code != mk_last_reg);
    assign mk_fin    = mk_change && (mk_code == MK_NONE)
                    && (mk_last_reg == MK_RIGHT) && (mk_prev_reg == MK_NONE);
    assign mk_mode   = mk_change && (mk_code == MK_NONE)
                    && (mk_last_reg == MK_LEFT) && (mk_prev_reg == MK_NONE);
    assign mk_cross  = mk_change && (mk_code == MK_NONE)
                    && ((mk_last_reg == MK_BOTH) || (mk_prev_reg == MK_BOTH)
                        || (mk_older_reg == MK_BOTH));
    // Ceiling of the mode that a toggle switches into.
    assign mark_ceil = precision_reg ? fast_speed_reg : slow_speed_reg;

    // ---------------- classification ----------------
    assign mag_e       = err_reg[ERROR_BITS-1] ? (~err_reg + 1'b1) : err_reg;
    assign mag         = MAG_W'(mag_e);
    assign is_curve    = mag > MAG_W'(turn_thr_reg);
    assign is_straight = mag < MAG_W'(straight_thr_reg);
    assign is_between  = !is_curve && !is_straight;
    // Only meaningful in the between case, where straight <= mag <= turn.
    assign span        = turn_thr_reg - straight_thr_reg;
    assign span_zero   = (span == '0);
    assign mag_off     = mag[THR_W-1:0] - straight_thr_reg;

    assign ceil_speed   = precision_reg ? slow_speed_reg : fast_speed_reg;
    assign spd_diff_neg = turn_speed_reg < ceil_speed;
    assign spd_diff_abs = spd_diff_neg ? (ceil_speed - turn_speed_reg)
                                       : (turn_speed_reg - ceil_speed);
    // The quotient never exceeds the speed difference, so this stays in range.
    assign interp = span_zero    ? ceil_speed :
                    spd_diff_neg ? (ceil_speed - div_quotient)
                                 : (ceil_speed + div_quotient);

    // ---------------- speed step ----------------
    always_comb begin
        base_target  = interp;
        in_curve_new = in_curve_reg;
        leaving_new  = leaving_reg;
        boost_new    = boost_reg;
        if (is_curve) begin
            base_target  = turn_speed_reg;
            in_curve_new = 1'b1;
            leaving_new  = 1'b0;
        end else if (is_straight) begin
            base_target  = ceil_speed;
            in_curve_new = 1'b0;
            if (in_curve_reg) begin
                leaving_new = 1'b1;
                boost_new   = boost_len_reg;
            end
        end
    end

    assign boost_on    = leaving_new && (boost_new != '0) && !precision_reg;
    assign boosted     = {1'b0, base_target} + BOOST_BONUS;
    assign target      = !boost_on             ? base_target :
                         (boosted > SPEED_MAX) ? SPEED_MAX[SPD_W-1:0] : boosted[SPD_W-1:0];
    assign boost_final = boost_on ? (boost_new - 1'b1) : boost_new;

    assign tgt9      = {1'b0, target};
    assign up        = tgt9 > speed_reg;
    assign step      = up ? accel_step_reg : decel_step_reg;
    assign adiff     = up ? (tgt9 - speed_reg) : (speed_reg - tgt9);
    assign speed_new = (adiff <= {1'b0, step}) ? tgt9 :
                       up ? (speed_reg + {1'b0, step}) : (speed_reg - {1'b0, step});

    // When the two bounds cross, the lower bound wins only for a speed below it; else the upper bound wins.
    assign res = (speed_new < {1'b0, turn_speed_reg}) ? turn_speed_reg :
                 (speed_new > {1'b0, ceil_speed})     ? ceil_speed : speed_new[SPD_W-1:0];

    // ---------------- register updates ----------------
    always_comb begin
        turn_thr_next     = turn_thr_reg;
        straight_thr_next = straight_thr_reg;
        turn_speed_next   = turn_speed_reg;
        slow_speed_next   = slow_speed_reg;
        fast_speed_next   = fast_speed_reg;
        boost_len_next    = boost_len_reg;
        accel_step_next   = accel_step_reg;
        decel_step_next   = decel_step_reg;
        speed_next        = speed_reg;
        in_curve_next     = in_curve_reg;
        leaving_next      = leaving_reg;
        boost_next        = boost_reg;
        precision_next    = precision_reg;
        mk_last_next      = mk_last_reg;
        mk_prev_next      = mk_prev_reg;
        mk_older_next     = mk_older_reg;
        ev_fin_next       = ev_fin_reg;
        ev_mode_next      = ev_mode_reg;
        ev_cross_next     = ev_cross_reg;
        err_next          = err_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TURN_THR:     turn_thr_next     = cfg_data[THR_W-1:0];
                REG_STRAIGHT_THR: straight_thr_next = cfg_data[THR_W-1:0];
                REG_TURN_SPEED:   turn_speed_next   = cfg_data[SPD_W-1:0];
                REG_SLOW_SPEED:   slow_speed_next   = cfg_data[SPD_W-1:0];
                REG_FAST_SPEED:   fast_speed_next   = cfg_data[SPD_W-1:0];
                REG_BOOST_LEN:    boost_len_next    = cfg_data[SPD_W-1:0];
                REG_ACCEL_STEP:   accel_step_next   = cfg_data[SPD_W-1:0];
                REG_DECEL_STEP:   decel_step_next   = cfg_data[SPD_W-1:0];
                default:          ;
            endcase
        end

        if (in_fire) begin
            err_next   = s_tdata[ERROR_BITS-1:0];
            left_next  = s_tdata[ERROR_BITS];
            right_next = s_tdata[ERROR_BITS+1];
        end

        if (mark_en) begin
            ev_fin_next   = mk_fin;
            ev_mode_next  = mk_mode;
            ev_cross_next = mk_cross;
            if (mk_change) begin
                mk_older_next = mk_prev_reg;
                mk_prev_next  = mk_last_reg;
                mk_last_next  = mk_code;
            end
            if (mk_mode) begin
                precision_next = !precision_reg;
                speed_next     = {1'b0, mark_ceil};
                in_curve_next  = 1'b0;
                leaving_next   = 1'b0;
                boost_next     = '0;
            end
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (done_en) begin
            speed_next    = speed_new;
            in_curve_next = in_curve_new;
            leaving_next  = leaving_new;
            boost_next    = boost_final;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0000, ev_cross_reg, ev_mode_reg, ev_fin_reg,
                             precision_reg, res};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            turn_thr_reg     <= RST_TURN_THR;
            straight_thr_reg <= RST_STRAIGHT_THR;
            turn_speed_reg   <= RST_TURN_SPEED;
            slow_speed_reg   <= RST_SLOW_SPEED;
            fast_speed_reg   <= RST_FAST_SPEED;
            boost_len_reg    <= RST_BOOST_LEN;
            accel_step_reg   <= RST_ACCEL_STEP;
            decel_step_reg   <= RST_DECEL_STEP;
            speed_reg        <= '0;
            in_curve_reg     <= 1'b0;
            leaving_reg      <= 1'b0;
            boost_reg        <= '0;
            precision_reg    <= 1'b0;
            mk_last_reg      <= MK_NONE;
            mk_prev_reg      <= MK_NONE;
            mk_older_reg     <= MK_NONE;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            turn_thr_reg     <= turn_thr_next;
            straight_thr_reg <= straight_thr_next;
            turn_speed_reg   <= turn_speed_next;
            slow_speed_reg   <= slow_speed_next;
            fast_speed_reg   <= fast_speed_next;
            boost_len_reg    <= boost_len_next;
            accel_step_reg   <= accel_step_next;
            decel_step_reg   <= decel_step_next;
            speed_reg        <= speed_next;
            in_curve_reg     <= in_curve_next;
            leaving_reg      <= leaving_next;
            boost_reg        <= boost_next;
            precision_reg    <= precision_next;
            mk_last_reg      <= mk_last_next;
            mk_prev_reg      <= mk_prev_next;
            mk_older_reg     <= mk_older_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        ev_fin_reg   <= ev_fin_next;
        ev_mode_reg  <= ev_mode_next;
        ev_cross_reg <= ev_cross_next;
        err_reg      <= err_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/lfsp_checker.sv
`timescale 1ns / 1ps

module lfsp_checker
    import lfsp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Requests are processed one at a time, so intake closes after each one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request was taken");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind line_follower_speed_profiler_top lfsp_checker u_lfsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
